FILE: hw/rtl/rtnb_pkg.sv
// rtnb_pkg: types, widths and codes shared by the radix tree node build unit.
// Used by rtnb_ctrl, rtnb_datapath and radix_tree_node_build_unit; depends on nothing.

package rtnb_pkg;

   localparam int MAX_LEAVES_DEF = 1024;
   localparam int CODE_W         = 30;
   localparam int IDX_W          = 10;
   localparam int CHILD_W        = 11;
   localparam int RANGE_W        = 10;
   localparam int PFX_W          = 8;
   localparam int TIE_BASE       = 32;

   localparam logic KIND_APPEND = 1'b0;
   localparam logic KIND_QUERY  = 1'b1;

   localparam logic STATUS_OK  = 1'b0;
   localparam logic STATUS_BAD = 1'b1;

   typedef struct packed {
      logic              kind;
      logic              start_new;
      logic [CODE_W-1:0] code;
      logic [IDX_W-1:0]  node_index;
   } req_type;

   typedef struct packed {
      logic [CHILD_W-1:0] left_child;
      logic               left_is_leaf;
      logic [CHILD_W-1:0] right_child;
      logic               right_is_leaf;
      logic [RANGE_W-1:0] range_first;
      logic [RANGE_W-1:0] range_last;
      logic               status;
   } rsp_type;

   typedef enum logic [4:0] {
      OP_IDLE,
      OP_APPEND,
      OP_LOAD,
      OP_ERROR,
      OP_RD_BASE,
      OP_RD_NEXT,
      OP_RD_PREV,
      OP_RD_EXP,
      OP_RD_BIN,
      OP_RD_J,
      OP_RD_SPLIT,
      OP_EV_BASE,
      OP_EV_NEXT,
      OP_EV_PREV,
      OP_EV_EXP,
      OP_EV_BIN,
      OP_EV_J,
      OP_EV_SPLIT,
      OP_HALVE,
      OP_RESULT
   } op_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CHECK,
      ST_EV_BASE,
      ST_RD_NEXT,
      ST_EV_NEXT,
      ST_RD_PREV,
      ST_EV_PREV,
      ST_RD_EXP,
      ST_EV_EXP,
      ST_RD_BIN,
      ST_EV_BIN,
      ST_RD_J,
      ST_EV_J,
      ST_SP_CHK,
      ST_SP_RD,
      ST_SP_EV
   } state_type;

   typedef struct packed {
      logic bad;
      logic gt;
      logic len_one;
      logic step_one;
      logic sstep_big;
      logic split_in;
   } stat_type;

endpackage

FILE: hw/rtl/radix_tree_node_build_unit.sv
// radix_tree_node_build_unit: top level of the radix tree node builder over sorted codes.
// Depends on rtnb_pkg, rtnb_ctrl and rtnb_datapath.
//
//   channel   ports                         beat taken when
//   request   start, busy, req_data         start high and busy low
//   response  rsp_valid, rsp_data           every cycle rsp_valid is high
//
// An append leaves busy low; a bad node index is caught in ST_CHECK and its beat comes from
// the registered response after the error op. Each code store read of a query is a read op
// then an evaluate op (one read port, registered data).
// Reset clears the code count and the sequencer; the store keeps no valid bits, no clearing.
// Results cannot be stalled: each response beat shows for exactly one cycle.

module radix_tree_node_build_unit #(
   parameter int MAX_LEAVES = rtnb_pkg::MAX_LEAVES_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  rtnb_pkg::req_type req_data,
   output logic              rsp_valid,
   output rtnb_pkg::rsp_type rsp_data
);

   rtnb_pkg::op_type   op;
   rtnb_pkg::stat_type stat;

   rtnb_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_kind (req_data.kind),
      .stat     (stat),
      .busy     (busy),
      .op       (op)
   );

   rtnb_datapath #(
      .MAX_LEAVES (MAX_LEAVES)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .op        (op),
      .req_data  (req_data),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

FILE: hw/rtl/rtnb_ctrl.sv
// rtnb_ctrl: sequencer for appends and node queries; issues one datapath op per cycle.
// Depends on rtnb_pkg (op_type, state_type, stat_type, kind codes).

module rtnb_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic              req_kind,
   input  rtnb_pkg::stat_type stat,
   output logic              busy,
   output rtnb_pkg::op_type  op
);

   rtnb_pkg::state_type state_ff;
   rtnb_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rtnb_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != rtnb_pkg::ST_IDLE);

   always_comb begin
      state_in = state_ff;
      op       = rtnb_pkg::OP_IDLE;
      case (state_ff)
         rtnb_pkg::ST_IDLE: begin
            if (start) begin
               if (req_kind == rtnb_pkg::KIND_QUERY) begin
                  op       = rtnb_pkg::OP_LOAD;
                  state_in = rtnb_pkg::ST_CHECK;
               end else begin
                  op = rtnb_pkg::OP_APPEND;
               end
            end
         end
         rtnb_pkg::ST_CHECK: begin
            if (stat.bad) begin
               op       = rtnb_pkg::OP_ERROR;
               state_in = rtnb_pkg::ST_IDLE;
            end else begin
               op       = rtnb_pkg::OP_RD_BASE;
               state_in = rtnb_pkg::ST_EV_BASE;
            end
         end
         rtnb_pkg::ST_EV_BASE: begin
            op       = rtnb_pkg::OP_EV_BASE;
            state_in = rtnb_pkg::ST_RD_NEXT;
         end
         rtnb_pkg::ST_RD_NEXT: begin
            op       = rtnb_pkg::OP_RD_NEXT;
            state_in = rtnb_pkg::ST_EV_NEXT;
         end
         rtnb_pkg::ST_EV_NEXT: begin
            op       = rtnb_pkg::OP_EV_NEXT;
            state_in = rtnb_pkg::ST_RD_PREV;
         end
         rtnb_pkg::ST_RD_PREV: begin
            op       = rtnb_pkg::OP_RD_PREV;
            state_in = rtnb_pkg::ST_EV_PREV;
         end
         rtnb_pkg::ST_EV_PREV: begin
            op       = rtnb_pkg::OP_EV_PREV;
            state_in = rtnb_pkg::ST_RD_EXP;
         end
         rtnb_pkg::ST_RD_EXP: begin
            op       = rtnb_pkg::OP_RD_EXP;
            state_in = rtnb_pkg::ST_EV_EXP;
         end
         rtnb_pkg::ST_EV_EXP: begin
            op = rtnb_pkg::OP_EV_EXP;
            if (stat.gt) begin
               state_in = rtnb_pkg::ST_RD_EXP;
            end else if (stat.len_one) begin
               state_in = rtnb_pkg::ST_RD_J;
            end else begin
               state_in = rtnb_pkg::ST_RD_BIN;
            end
         end
         rtnb_pkg::ST_RD_BIN: begin
            op       = rtnb_pkg::OP_RD_BIN;
            state_in = rtnb_pkg::ST_EV_BIN;
         end
         rtnb_pkg::ST_EV_BIN: begin
            op = rtnb_pkg::OP_EV_BIN;
            if (stat.step_one) begin
               state_in = rtnb_pkg::ST_RD_J;
            end else begin
               state_in = rtnb_pkg::ST_RD_BIN;
            end
         end
         rtnb_pkg::ST_RD_J: begin
            op       = rtnb_pkg::OP_RD_J;
            state_in = rtnb_pkg::ST_EV_J;
         end
         rtnb_pkg::ST_EV_J: begin
            op       = rtnb_pkg::OP_EV_J;
            state_in = rtnb_pkg::ST_SP_CHK;
         end
         rtnb_pkg::ST_SP_CHK: begin
            if (stat.sstep_big) begin
               op       = rtnb_pkg::OP_HALVE;
               state_in = rtnb_pkg::ST_SP_RD;
            end else begin
               op       = rtnb_pkg::OP_RESULT;
               state_in = rtnb_pkg::ST_IDLE;
            end
         end
         rtnb_pkg::ST_SP_RD: begin
            if (stat.split_in) begin
               op       = rtnb_pkg::OP_RD_SPLIT;
               state_in = rtnb_pkg::ST_SP_EV;
            end else begin
               state_in = rtnb_pkg::ST_SP_CHK;
            end
         end
         rtnb_pkg::ST_SP_EV: begin
            op       = rtnb_pkg::OP_EV_SPLIT;
            state_in = rtnb_pkg::ST_SP_CHK;
         end
         default: begin
            state_in = rtnb_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

FILE: hw/rtl/rtnb_datapath.sv
// rtnb_datapath: code store, probe address unit, prefix length compare and search registers.
// Depends on rtnb_pkg (req_type, rsp_type, op_type, stat_type, widths).

module rtnb_datapath #(
   parameter int MAX_LEAVES = rtnb_pkg::MAX_LEAVES_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  rtnb_pkg::op_type  op,
   input  rtnb_pkg::req_type req_data,
   output rtnb_pkg::stat_type stat,
   output logic              rsp_valid,
   output rtnb_pkg::rsp_type rsp_data
);

   localparam int PW      = $clog2(MAX_LEAVES);
   localparam int CW      = $clog2(MAX_LEAVES + 1);
   localparam int LW      = PW + 2;
   localparam int MW      = LW + 1;
   localparam int SW      = PW + 4;
   localparam int EW      = ((CW > rtnb_pkg::IDX_W) ? CW : rtnb_pkg::IDX_W) + 1;
   localparam int HW      = CW + 1;
   localparam int CODE_W  = rtnb_pkg::CODE_W;
   localparam int IDX_W   = rtnb_pkg::IDX_W;
   localparam int PFX_W   = rtnb_pkg::PFX_W;
   localparam int CHILD_W = rtnb_pkg::CHILD_W;
   localparam int RANGE_W = rtnb_pkg::RANGE_W;

   function automatic logic [5:0] clz32(input logic [31:0] x);
      logic [5:0] c;
      c = 6'd32;
      for (int k = 0; k < 32; k++) begin
         if (x[k]) begin
            c = 6'(31 - k);
         end
      end
      return c;
   endfunction

   logic [CODE_W-1:0] mem [MAX_LEAVES];

   logic [CW-1:0]           count_ff;
   logic [IDX_W-1:0]        idx_ff;
   logic [CODE_W-1:0]       base_code_ff;
   logic [PW-1:0]           base_pos_ff;
   logic [CODE_W-1:0]       rd_ff;
   logic signed [SW-1:0]    probe_ff;
   logic                    pin_ff;
   logic signed [PFX_W-1:0] pnext_ff;
   logic signed [PFX_W-1:0] thr_ff;
   logic                    dir_ff;
   logic [LW-1:0]           len_ff;
   logic [LW-1:0]           step_ff;
   logic [LW-1:0]           bound_ff;
   logic [PW-1:0]           first_ff;
   logic [PW-1:0]           last_ff;
   logic [PW-1:0]           split_ff;
   logic [PW-1:0]           sstep_ff;
   rtnb_pkg::rsp_type       rsp_ff;
   logic                    rsp_valid_ff;

   logic [CW-1:0]           cnt_eff;
   logic                    wr_en;
   logic signed [SW-1:0]    ipos;
   logic signed [SW-1:0]    org;
   logic [MW-1:0]           mag;
   logic                    neg;
   logic signed [SW-1:0]    pos_in;
   logic                    in_rng;
   logic                    rd_op;
   logic signed [PFX_W-1:0] pfx;
   logic                    gt;
   logic [PW-1:0]           ipw;
   logic [PW-1:0]           jpw;
   logic [PW-1:0]           new_first;
   logic [PW-1:0]           new_last;
   logic [PW:0]             split_sum;
   logic                    lleaf;
   logic                    rleaf;
   logic [HW-1:0]           lchild;
   logic [HW-1:0]           rchild;
   rtnb_pkg::rsp_type       rsp_in;

   assign cnt_eff = req_data.start_new ? '0 : count_ff;
   assign wr_en   = (op == rtnb_pkg::OP_APPEND) && (cnt_eff < CW'(MAX_LEAVES));
   assign ipos    = SW'(idx_ff);
   assign ipw     = ipos[PW-1:0];
   assign jpw     = probe_ff[PW-1:0];

   assign rd_op = (op == rtnb_pkg::OP_RD_BASE) || (op == rtnb_pkg::OP_RD_NEXT) ||
                  (op == rtnb_pkg::OP_RD_PREV) || (op == rtnb_pkg::OP_RD_EXP) ||
                  (op == rtnb_pkg::OP_RD_BIN) || (op == rtnb_pkg::OP_RD_J) ||
                  (op == rtnb_pkg::OP_RD_SPLIT);

   always_comb begin
      org = ipos;
      mag = '0;
      neg = 1'b0;
      case (op)
         rtnb_pkg::OP_RD_NEXT: begin
            mag = MW'(1);
         end
         rtnb_pkg::OP_RD_PREV: begin
            mag = MW'(1);
            neg = 1'b1;
         end
         rtnb_pkg::OP_RD_EXP: begin
            mag = {1'b0, len_ff};
            neg = !dir_ff;
         end
         rtnb_pkg::OP_RD_BIN: begin
            mag = {1'b0, bound_ff} + {1'b0, step_ff};
            neg = !dir_ff;
         end
         rtnb_pkg::OP_RD_J: begin
            mag = {1'b0, bound_ff};
            neg = !dir_ff;
         end
         rtnb_pkg::OP_RD_SPLIT: begin
            org = SW'(split_ff);
            mag = MW'(sstep_ff);
         end
         default: begin
            mag = '0;
         end
      endcase
      pos_in = neg ? (org - SW'(mag)) : (org + SW'(mag));
   end

   assign in_rng = !pos_in[SW-1] && (pos_in[SW-2:0] < (SW-1)'(count_ff));

   always_comb begin
      if (!pin_ff) begin
         pfx = {PFX_W{1'b1}};
      end else if (rd_ff != base_code_ff) begin
         pfx = PFX_W'(clz32(32'(rd_ff ^ base_code_ff)));
      end else begin
         pfx = PFX_W'(rtnb_pkg::TIE_BASE) + PFX_W'(clz32(32'(base_pos_ff ^ jpw)));
      end
   end

   assign gt        = (pfx > thr_ff);
   assign new_first = dir_ff ? ipw : jpw;
   assign new_last  = dir_ff ? jpw : ipw;
   assign split_sum = {1'b0, split_ff} + {1'b0, sstep_ff};

   assign stat.bad       = ((EW'(idx_ff) + EW'(1)) >= EW'(count_ff));
   assign stat.gt        = gt;
   assign stat.len_one   = (len_ff == LW'(1));
   assign stat.step_one  = (step_ff == LW'(1));
   assign stat.sstep_big = (sstep_ff > PW'(1));
   assign stat.split_in  = (split_sum < {1'b0, last_ff});

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[cnt_eff[PW-1:0]] <= req_data.code;
      end
      if (rd_op && in_rng) begin
         rd_ff <= mem[pos_in[PW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (op == rtnb_pkg::OP_APPEND) begin
            count_ff <= wr_en ? (cnt_eff + CW'(1)) : cnt_eff;
         end
         rsp_valid_ff <= (op == rtnb_pkg::OP_RESULT) || (op == rtnb_pkg::OP_ERROR);
      end
   end

   always_ff @(posedge clock) begin
      if (rd_op) begin
         probe_ff <= pos_in;
         pin_ff   <= in_rng;
      end
      case (op)
         rtnb_pkg::OP_LOAD: begin
            idx_ff <= req_data.node_index;
         end
         rtnb_pkg::OP_EV_BASE: begin
            base_code_ff <= rd_ff;
            base_pos_ff  <= ipw;
         end
         rtnb_pkg::OP_EV_NEXT: begin
            pnext_ff <= pfx;
         end
         rtnb_pkg::OP_EV_PREV: begin
            dir_ff   <= (pnext_ff > pfx);
            thr_ff   <= (pnext_ff > pfx) ? pfx : pnext_ff;
            len_ff   <= LW'(1);
            bound_ff <= '0;
         end
         rtnb_pkg::OP_EV_EXP: begin
            if (gt) begin
               len_ff <= len_ff << 1;
            end else begin
               step_ff <= len_ff >> 1;
            end
         end
         rtnb_pkg::OP_EV_BIN: begin
            if (gt) begin
               bound_ff <= bound_ff + step_ff;
            end
            step_ff <= step_ff >> 1;
         end
         rtnb_pkg::OP_EV_J: begin
            thr_ff   <= pfx;
            first_ff <= new_first;
            last_ff  <= new_last;
            split_ff <= new_first;
            sstep_ff <= new_last - new_first;
            if (!dir_ff) begin
               base_code_ff <= rd_ff;
               base_pos_ff  <= jpw;
            end
         end
         rtnb_pkg::OP_HALVE: begin
            sstep_ff <= PW'(({1'b0, sstep_ff} + (PW+1)'(1)) >> 1);
         end
         rtnb_pkg::OP_EV_SPLIT: begin
            if (gt) begin
               split_ff <= split_sum[PW-1:0];
            end
         end
         default: begin
            idx_ff <= idx_ff;
         end
      endcase
   end

   always_comb begin
      lleaf  = (split_ff == first_ff);
      rleaf  = (split_sum == {1'b0, last_ff}) && (sstep_ff == PW'(1)) ||
               (({1'b0, split_ff} + (PW+1)'(1)) == {1'b0, last_ff});
      lchild = lleaf ? (HW'(count_ff) - HW'(1) + HW'(split_ff)) : HW'(split_ff);
      rchild = rleaf ? (HW'(count_ff) + HW'(split_ff)) : (HW'(split_ff) + HW'(1));
      rsp_in = '0;
      if (op == rtnb_pkg::OP_ERROR) begin
         rsp_in.status = rtnb_pkg::STATUS_BAD;
      end else begin
         rsp_in.left_child    = CHILD_W'(lchild);
         rsp_in.left_is_leaf  = lleaf;
         rsp_in.right_child   = CHILD_W'(rchild);
         rsp_in.right_is_leaf = rleaf;
         rsp_in.range_first   = RANGE_W'(first_ff);
         rsp_in.range_last    = RANGE_W'(last_ff);
         rsp_in.status        = rtnb_pkg::STATUS_OK;
      end
   end

   always_ff @(posedge clock) begin
      if ((op == rtnb_pkg::OP_RESULT) || (op == rtnb_pkg::OP_ERROR)) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

FILE: tb/tb.sv
// tb: self-checking bench for radix_tree_node_build_unit. It loads code sets, most
// sorted, and queries internal nodes, predicting children, leaf flags and range
// in-bench. Depends on rtnb_pkg and radix_tree_node_build_unit.

module tb;

   localparam int CODE_TOP     = 32'h3FFF_FFFF;
   localparam int IDX_TOP      = 1023;
   localparam int RANDOM_BEATS = 320;
   localparam int LIMIT_CYCLES = 600000;

   logic              clock;
   logic              reset;
   logic              start;
   logic              busy;
   rtnb_pkg::req_type req_data;
   logic              rsp_valid;
   rtnb_pkg::rsp_type rsp_data;

   logic [rtnb_pkg::CODE_W-1:0] codes_held [rtnb_pkg::MAX_LEAVES_DEF];
   int                          held_n;
   rtnb_pkg::rsp_type           nodes_due [$];
   int                          beats_taken;
   int                          mismatches;
   bit                          quiet;

   radix_tree_node_build_unit uut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #(LIMIT_CYCLES * 12);
      $display("end of test: mismatches");
      $finish;
   end

   function automatic int lead_zeros(logic [31:0] x);
      int c;
      c = 0;
      for (int k = 31; k >= 0 && !x[k]; k--)
         c++;
      return c;
   endfunction

   function automatic int shared_prefix(int a, int b);
      logic [31:0] ca;
      logic [31:0] cb;
      if (a < 0 || a >= held_n || b < 0 || b >= held_n)
         return -1;
      ca = {2'b00, codes_held[a]};
      cb = {2'b00, codes_held[b]};
      if (ca != cb)
         return lead_zeros(ca ^ cb);
      return rtnb_pkg::TIE_BASE + lead_zeros(32'(a ^ b));
   endfunction

   function automatic rtnb_pkg::rsp_type build_node(int i);
      rtnb_pkg::rsp_type r;
      int      d, dmin, span, bound, stride, j, lo, hi, common, split;
      logic    lleaf, rleaf;
      r = '0;
      if (held_n < 2 || i >= held_n - 1) begin
         r.status = rtnb_pkg::STATUS_BAD;
         return r;
      end
      d = shared_prefix(i, i + 1) > shared_prefix(i, i - 1) ? 1 : -1;
      dmin = shared_prefix(i, i - d);
      span = 1;
      while (shared_prefix(i, i + span * d) > dmin)
         span = span * 2;
      bound = 0;
      for (stride = span / 2; stride > 0; stride = stride / 2)
         if (shared_prefix(i, i + (bound + stride) * d) > dmin)
            bound = bound + stride;
      j = i + bound * d;
      lo = i < j ? i : j;
      hi = i < j ? j : i;
      common = shared_prefix(lo, hi);
      split = lo;
      stride = hi - lo;
      while (stride > 1) begin
         stride = (stride + 1) / 2;
         if (split + stride < hi && shared_prefix(lo, split + stride) > common)
            split = split + stride;
      end
      lleaf = (split == lo);
      rleaf = (split + 1 == hi);
      r.left_child    = rtnb_pkg::CHILD_W'(lleaf ? held_n - 1 + split : split);
      r.left_is_leaf  = lleaf;
      r.right_child   = rtnb_pkg::CHILD_W'(rleaf ? held_n + split : split + 1);
      r.right_is_leaf = rleaf;
      r.range_first   = rtnb_pkg::RANGE_W'(lo);
      r.range_last    = rtnb_pkg::RANGE_W'(hi);
      r.status        = rtnb_pkg::STATUS_OK;
      return r;
   endfunction

   function automatic void take_beat(rtnb_pkg::req_type r);
      if (r.kind == rtnb_pkg::KIND_APPEND) begin
         if (r.start_new)
            held_n = 0;
         if (held_n < rtnb_pkg::MAX_LEAVES_DEF) begin
            codes_held[held_n] = r.code;
            held_n++;
         end
      end else begin
         nodes_due.insert(nodes_due.size(), build_node(int'(r.node_index)));
      end
   endfunction

   function automatic string show(rtnb_pkg::rsp_type v);
      return $sformatf("left=%0d/%0b right=%0d/%0b range=%0d..%0d status=%0b",
                       v.left_child, v.left_is_leaf, v.right_child, v.right_is_leaf,
                       v.range_first, v.range_last, v.status);
   endfunction

   task automatic flag(string what);
      mismatches++;
      if (mismatches <= 10)
         $display("MISMATCH at %0t: %s", $time, what);
   endtask

   always @(posedge clock) begin : rsp_check
      rtnb_pkg::rsp_type want;
      if (!reset && rsp_valid) begin
         if (nodes_due.size() == 0) begin
            flag($sformatf("unexpected beat %s", show(rsp_data)));
         end else begin
            want = nodes_due.pop_front();
            if (rsp_data.left_child !== want.left_child ||
                rsp_data.left_is_leaf !== want.left_is_leaf ||
                rsp_data.right_child !== want.right_child ||
                rsp_data.right_is_leaf !== want.right_is_leaf ||
                rsp_data.range_first !== want.range_first ||
                rsp_data.range_last !== want.range_last ||
                rsp_data.status !== want.status)
               flag($sformatf("expected %s actual %s", show(want), show(rsp_data)));
         end
      end
   end

   // call at a falling edge; returns at a falling edge with start still high
   task automatic send_beat(rtnb_pkg::req_type r);
      while (!quiet && $urandom_range(99) < 22) begin
         start <= 1'b0;
         @(negedge clock);
      end
      start    <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (busy);
      take_beat(r);
      beats_taken++;
      @(negedge clock);
   endtask

   task automatic append_code(logic fresh, logic [rtnb_pkg::CODE_W-1:0] c);
      rtnb_pkg::req_type r;
      r.kind       = rtnb_pkg::KIND_APPEND;
      r.start_new  = fresh;
      r.code       = c;
      r.node_index = rtnb_pkg::IDX_W'($urandom);
      send_beat(r);
   endtask

   task automatic query_node(int idx);
      rtnb_pkg::req_type r;
      r.kind       = rtnb_pkg::KIND_QUERY;
      r.start_new  = 1'($urandom);
      r.code       = rtnb_pkg::CODE_W'($urandom);
      r.node_index = rtnb_pkg::IDX_W'(idx);
      send_beat(r);
   endtask

   task automatic load_sorted_set(int n, int sh, logic [31:0] base);
      logic [31:0] acc;
      logic [31:0] mask;
      acc = base;
      mask = (32'd1 << sh) - 32'd1;
      for (int k = 0; k < n; k++) begin
         if (k > 0 && $urandom_range(3) != 0)
            acc = acc + ($urandom & mask);
         if (acc > CODE_TOP)
            acc = CODE_TOP;
         append_code(k == 0, acc[rtnb_pkg::CODE_W-1:0]);
      end
   endtask

   task automatic test_empty_store;
      query_node(0);
      query_node(IDX_TOP);
      append_code(1'b1, rtnb_pkg::CODE_W'(CODE_TOP));
      query_node(0);
   endtask

   task automatic test_small_set;
      logic [rtnb_pkg::CODE_W-1:0] pattern [8];
      pattern = '{30'h0, 30'h0, 30'h5, 30'h5, 30'h5, 30'h100, 30'h3FFF_FFFE, 30'h3FFF_FFFF};
      for (int k = 0; k < 8; k++)
         append_code(k == 0, pattern[k]);
      for (int k = 0; k < 8; k++)
         query_node(k);
   endtask

   task automatic test_equal_codes;
      for (int k = 0; k < 4; k++)
         append_code(k == 0, 30'h2AAA_AAAA);
      for (int k = 0; k < 3; k++)
         query_node(k);
   endtask

   task automatic test_store_full;
      load_sorted_set(rtnb_pkg::MAX_LEAVES_DEF, 19, 32'd0);
      append_code(1'b0, rtnb_pkg::CODE_W'(CODE_TOP));
      append_code(1'b0, '0);
      query_node(0);
      query_node(rtnb_pkg::MAX_LEAVES_DEF - 2);
      query_node(511);
      repeat (8) query_node($urandom_range(0, rtnb_pkg::MAX_LEAVES_DEF - 2));
      query_node(IDX_TOP);
      append_code(1'b1, 30'h155);
      query_node(0);
      append_code(1'b0, 30'h156);
      query_node(0);
   endtask

   task automatic test_random_sets;
      int first_beat, shape, n, idx;
      first_beat = beats_taken;
      while (beats_taken - first_beat < RANDOM_BEATS) begin
         quiet = (beats_taken - first_beat >= 100) && (beats_taken - first_beat < 220);
         shape = $urandom_range(99);
         if (shape < 75) begin
            load_sorted_set($urandom_range(2, 32), $urandom_range(0, 24),
                            32'($urandom_range(0, CODE_TOP)) >> $urandom_range(0, 10));
         end else if (shape < 85) begin
            load_sorted_set($urandom_range(33, 160), $urandom_range(0, 20),
                            32'($urandom_range(0, CODE_TOP)) >> $urandom_range(0, 10));
         end else if (shape < 92) begin
            n = $urandom_range(2, 24);
            for (int k = 0; k < n; k++)
               append_code(k == 0, rtnb_pkg::CODE_W'($urandom));
         end else if (shape < 96) begin
            append_code(1'b1, rtnb_pkg::CODE_W'($urandom));
         end else begin
            repeat ($urandom_range(1, 4)) append_code(1'b0, rtnb_pkg::CODE_W'($urandom));
         end
         repeat ($urandom_range(2, 16)) begin
            if (held_n >= 2 && $urandom_range(9) != 0)
               idx = $urandom_range(0, held_n - 2);
            else
               idx = $urandom_range(0, IDX_TOP);
            query_node(idx);
         end
      end
      quiet = 1'b0;
   endtask

   initial begin : main
      int waited;
      reset       = 1'b1;
      start       = 1'b0;
      req_data    = '0;
      held_n      = 0;
      beats_taken = 0;
      mismatches  = 0;
      quiet       = 1'b0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_empty_store();
      test_small_set();
      test_equal_codes();
      test_store_full();
      test_random_sets();

      start <= 1'b0;
      waited = 0;
      while (nodes_due.size() != 0 && waited < 5000) begin
         @(posedge clock);
         waited++;
      end
      repeat (100) @(posedge clock);
      if (mismatches == 0 && nodes_due.size() == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule
